// ===== sv/bmp565_pkg.sv =====
// Shared types and constants of the BMP 24-bit to RGB565 stream decoder.
`default_nettype none
package bmp565_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
  localparam logic [31:0] HEADER_BYTES  = 32'd34;
  localparam logic [15:0] BITS_24       = 16'd24;
  localparam logic [15:0] PLANES_ONE    = 16'd1;

  // outcome codes
  localparam logic [1:0] OUT_PIXEL      = 2'd0;
  localparam logic [1:0] OUT_NOT_BMP    = 2'd1;
  localparam logic [1:0] OUT_UNSUPPORTED = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_ORIGIN_X      = 2'd0;
  localparam logic [1:0] REG_ORIGIN_Y      = 2'd1;
  localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd2;
  localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd3;

  localparam logic [15:0] SCREEN_WIDTH_RESET  = 16'd240;
  localparam logic [15:0] SCREEN_HEIGHT_RESET = 16'd320;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       start_of_file;
  } byte_item_t;

  typedef struct packed {
    logic [15:0]        pixel_color;
    logic signed [15:0] pixel_column;
    logic signed [15:0] pixel_row;
    logic [1:0]         outcome;
    logic               last_pixel;
  } pixel_item_t;

  typedef struct packed {
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic [15:0]        screen_width;
    logic [15:0]        screen_height;
  } cfg_t;

  // one classified request from the parser to the pixel stage
  typedef struct packed {
    logic [1:0]  outcome;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [15:0] column;
    logic [15:0] row_term;
    logic        last;
  } work_t;

endpackage
`default_nettype wire

// ===== sv/bmp24_to_rgb565_stream_unit.sv =====
// Top level of the BMP 24-bit to RGB565 stream decoder.
// Takes one file byte per clock on push/full and yields one result per clock on
// empty/pop. A byte is taken whenever the request queue between the parser and
// the pixel stage has room (depth QUEUE_DEPTH, default 4); the parser handles each
// byte as it is taken, and a result waits in the output register until popped.
// Configuration registers (origin_x, origin_y, screen_width, screen_height) are
// always ready and should be written only while no file is being decoded.
`default_nettype none
module bmp24_to_rgb565_stream_unit
  import bmp565_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire byte_item_t  byte_item,
  output logic             empty,
  input  wire logic        pop,
  output pixel_item_t      pixel_item,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  cfg_t  cfg;
  logic  accept, work_push, q_rd, q_nonempty;
  work_t work, q_data;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_x      <= '0;
      cfg.origin_y      <= '0;
      cfg.screen_width  <= SCREEN_WIDTH_RESET;
      cfg.screen_height <= SCREEN_HEIGHT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ORIGIN_X:      cfg.origin_x      <= $signed(cfg_data);
        REG_ORIGIN_Y:      cfg.origin_y      <= $signed(cfg_data);
        REG_SCREEN_WIDTH:  cfg.screen_width  <= cfg_data;
        REG_SCREEN_HEIGHT: cfg.screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  bmp565_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .accept    (accept),
    .byte_item (byte_item),
    .work_push (work_push),
    .work      (work)
  );

  bmp565_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (work_push),
    .wr_data  (work),
    .rd_en    (q_rd),
    .rd_data  (q_data),
    .full     (full),
    .nonempty (q_nonempty)
  );

  bmp565_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_nonempty (q_nonempty),
    .q_data     (q_data),
    .q_rd       (q_rd),
    .pop        (pop),
    .empty      (empty),
    .pixel_item (pixel_item)
  );

endmodule
`default_nettype wire

// ===== sv/bmp565_front.sv =====
// Header parser and pixel sequencer: classifies each file byte.
`default_nettype none
module bmp565_front
  import bmp565_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cfg_t       cfg,
  input  wire logic       accept,
  input  wire byte_item_t byte_item,
  output logic            work_push,
  output work_t           work
);

  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_SKIP   = 3'd1;
  localparam logic [2:0] PH_PIXEL  = 3'd2;
  localparam logic [2:0] PH_PAD    = 3'd3;
  localparam logic [2:0] PH_IDLE   = 3'd4;

  logic [2:0]  phase, phase_next;
  logic [31:0] position, position_next;
  logic [31:0] data_offset, data_offset_next;
  logic [31:0] field_shift, field_shift_next;
  logic [15:0] image_width, image_width_next;
  logic [15:0] image_height, image_height_next;
  logic [15:0] column_count, column_count_next;
  logic [15:0] row_count, row_count_next;
  logic [1:0]  triplet_index, triplet_index_next;
  logic [7:0]  saved_blue, saved_blue_next;
  logic [7:0]  saved_green, saved_green_next;
  logic [1:0]  padding_left, padding_left_next;

  // values seen by this byte once a start mark has restarted the parse
  logic [2:0]  ph_c;
  logic [31:0] pos_c, doff_c, fs_c;
  logic [15:0] w_c, h_c, col_c, row_c;
  logic [1:0]  tri_c, pad_c;
  logic [7:0]  blue_c, green_c;
  logic        off_screen, is_last, do_pixel;

  always_comb begin
    logic sof;
    sof     = byte_item.start_of_file;
    ph_c    = sof ? PH_HEADER : phase;
    pos_c   = sof ? '0 : position;
    doff_c  = sof ? '0 : data_offset;
    fs_c    = sof ? '0 : field_shift;
    w_c     = sof ? '0 : image_width;
    h_c     = sof ? '0 : image_height;
    col_c   = sof ? '0 : column_count;
    row_c   = sof ? '0 : row_count;
    tri_c   = sof ? '0 : triplet_index;
    pad_c   = sof ? '0 : padding_left;
    blue_c  = sof ? '0 : saved_blue;
    green_c = sof ? '0 : saved_green;
  end

  assign off_screen = ($signed({cfg.origin_x[15], cfg.origin_x}) >=
                       $signed({1'b0, cfg.screen_width})) ||
                      ($signed({cfg.origin_y[15], cfg.origin_y}) >=
                       $signed({1'b0, cfg.screen_height}));
  assign is_last = (row_c == h_c - 16'd1) && (col_c == w_c - 16'd1);

  always_comb begin
    phase_next         = ph_c;
    position_next      = pos_c + 32'd1;
    data_offset_next   = doff_c;
    field_shift_next   = fs_c;
    image_width_next   = w_c;
    image_height_next  = h_c;
    column_count_next  = col_c;
    row_count_next     = row_c;
    triplet_index_next = tri_c;
    saved_blue_next    = blue_c;
    saved_green_next   = green_c;
    padding_left_next  = pad_c;
    work_push          = 1'b0;
    do_pixel           = 1'b0;
    work               = '0;
    work.outcome       = OUT_PIXEL;

    case (ph_c)
      PH_HEADER: begin
        if (pos_c == '0 && off_screen) begin
          phase_next = PH_IDLE;
        end else begin
          field_shift_next = {byte_item.file_byte, fs_c[31:8]};
          case (pos_c)
            32'd1: begin
              if (field_shift_next[31:16] != BMP_SIGNATURE) begin
                work_push    = 1'b1;
                work.outcome = OUT_NOT_BMP;
                phase_next   = PH_IDLE;
              end
            end
            32'd13: data_offset_next  = field_shift_next;
            32'd21: image_width_next  = field_shift_next[15:0];
            32'd25: image_height_next = field_shift_next[15:0];
            32'd27: begin
              if (field_shift_next[31:16] != PLANES_ONE) begin
                work_push    = 1'b1;
                work.outcome = OUT_UNSUPPORTED;
                phase_next   = PH_IDLE;
              end
            end
            32'd29: begin
              if (field_shift_next[31:16] != BITS_24) begin
                work_push    = 1'b1;
                work.outcome = OUT_UNSUPPORTED;
                phase_next   = PH_IDLE;
              end
            end
            HEADER_BYTES - 32'd1: begin
              if (field_shift_next != '0 || doff_c < HEADER_BYTES) begin
                work_push    = 1'b1;
                work.outcome = OUT_UNSUPPORTED;
                phase_next   = PH_IDLE;
              end else if (w_c == '0 || h_c == '0) begin
                phase_next = PH_IDLE;
              end else begin
                phase_next = PH_SKIP;
              end
            end
            default: ;
          endcase
        end
      end
      PH_SKIP: begin
        if (pos_c == doff_c) begin
          phase_next = PH_PIXEL;
          do_pixel   = 1'b1;
        end
      end
      PH_PIXEL: do_pixel = 1'b1;
      PH_PAD: begin
        padding_left_next = pad_c - 2'd1;
        if (padding_left_next == '0) phase_next = PH_PIXEL;
      end
      default: ;
    endcase

    if (do_pixel) begin
      case (tri_c)
        2'd0: begin
          saved_blue_next    = byte_item.file_byte;
          triplet_index_next = 2'd1;
        end
        2'd1: begin
          saved_green_next   = byte_item.file_byte;
          triplet_index_next = 2'd2;
        end
        default: begin
          triplet_index_next = 2'd0;
          work_push          = 1'b1;
          work.blue          = blue_c;
          work.green         = green_c;
          work.red           = byte_item.file_byte;
          work.column        = col_c;
          work.row_term      = h_c - 16'd1 - row_c;
          work.last          = is_last;
          column_count_next  = col_c + 16'd1;
          if (is_last) begin
            phase_next = PH_IDLE;
          end else if (column_count_next == w_c) begin
            column_count_next = '0;
            row_count_next    = row_c + 16'd1;
            // rows pad to four bytes: 3*w mod 4 leaves w mod 4 bytes to drop
            padding_left_next = w_c[1:0];
            if (w_c[1:0] != 2'd0) phase_next = PH_PAD;
          end
        end
      endcase
    end

    work_push = work_push && accept;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      position      <= '0;
      data_offset   <= '0;
      field_shift   <= '0;
      image_width   <= '0;
      image_height  <= '0;
      column_count  <= '0;
      row_count     <= '0;
      triplet_index <= '0;
      saved_blue    <= '0;
      saved_green   <= '0;
      padding_left  <= '0;
    end else if (accept) begin
      phase         <= phase_next;
      position      <= position_next;
      data_offset   <= data_offset_next;
      field_shift   <= field_shift_next;
      image_width   <= image_width_next;
      image_height  <= image_height_next;
      column_count  <= column_count_next;
      row_count     <= row_count_next;
      triplet_index <= triplet_index_next;
      saved_blue    <= saved_blue_next;
      saved_green   <= saved_green_next;
      padding_left  <= padding_left_next;
    end
  end

endmodule
`default_nettype wire

// ===== sv/bmp565_queue.sv =====
// Short request queue between the parser and the pixel stage.
`default_nettype none
module bmp565_queue
  import bmp565_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  wr_en,
  input  wire work_t wr_data,
  input  wire logic  rd_en,
  output work_t      rd_data,
  output logic       full,
  output logic       nonempty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  work_t         mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full     = (count == FULL_COUNT);
  assign nonempty = (count != '0);
  assign rd_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      if (rd_en) rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      if (wr_en && !rd_en) count <= count + CW'(1);
      else if (rd_en && !wr_en) count <= count - CW'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && full)) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(rd_en && !nonempty)) else $error("queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT) else $error("queue count beyond depth");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (wr_en && !rd_en) |=> count == $past(count) + CW'(1))
    else $error("queue count missed a write");

endmodule
`default_nettype wire

// ===== sv/bmp565_back.sv =====
// Pixel stage: packs RGB565, places coordinates and holds the result register.
`default_nettype none
module bmp565_back
  import bmp565_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  input  wire logic  q_nonempty,
  input  wire work_t q_data,
  output logic       q_rd,
  input  wire logic  pop,
  output logic       empty,
  output pixel_item_t pixel_item
);

  logic        out_valid;
  pixel_item_t result_next;

  assign empty = !out_valid;
  assign q_rd  = q_nonempty && (!out_valid || pop);

  always_comb begin
    result_next = '0;
    result_next.outcome = q_data.outcome;
    if (q_data.outcome == OUT_PIXEL) begin
      result_next.pixel_color  = {q_data.red[7:3], q_data.green[7:2], q_data.blue[7:3]};
      result_next.pixel_column = cfg.origin_x + $signed(q_data.column);
      result_next.pixel_row    = cfg.origin_y + $signed(q_data.row_term);
      result_next.last_pixel   = q_data.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_rd) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) pixel_item <= result_next;
  end

  a_hold_unpopped: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pop) |=> out_valid && $stable(pixel_item))
    else $error("result changed before it was taken");
  a_error_fields_clear: assert property (@(posedge clk) disable iff (rst)
    (out_valid && pixel_item.outcome != OUT_PIXEL) |->
      (pixel_item.pixel_color == '0 && pixel_item.last_pixel == 1'b0))
    else $error("error result carries pixel data");
  a_refill: assert property (@(posedge clk) disable iff (rst)
    (q_nonempty && !out_valid) |=> out_valid)
    else $error("result register not refilled");

endmodule
`default_nettype wire
